// File: hw/rtl/tet_pkg.sv
// Shared types and constants of the touch event tracker.
package tet_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned DeltaW   = 13;
  localparam int unsigned CfgAddrW = 8;

  localparam logic [CfgAddrW-1:0] RegXExtent = 8'd0;
  localparam logic [CfgAddrW-1:0] RegYExtent = 8'd1;

  localparam logic [CoordW-1:0] XExtentReset = 12'd480;
  localparam logic [CoordW-1:0] YExtentReset = 12'd800;
  localparam logic [CoordW-1:0] NoTouchCoord = 12'hFFF;
  localparam logic [3:0]        OneTouchNib  = 4'h1;

  localparam logic [1:0] StNone      = 2'd0;
  localparam logic [1:0] StJustTouch = 2'd1;
  localparam logic [1:0] StTouched   = 2'd2;
  localparam logic [1:0] StJustPop   = 2'd3;

  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirPos  = 2'd1;
  localparam logic [1:0] DirNeg  = 2'd2;

  typedef enum logic [3:0] {
    TrkNone      = 4'b0001,
    TrkJustTouch = 4'b0010,
    TrkTouched   = 4'b0100,
    TrkJustPop   = 4'b1000
  } trk_state_e;

  // Packed so that the status byte sits in the lowest bits.
  typedef struct packed {
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] status_byte;
  } item_t;

  // Packed so that pos_x sits in the lowest bits.
  typedef struct packed {
    logic [1:0]               dir_y;
    logic [1:0]               dir_x;
    logic signed [DeltaW-1:0] delta_y;
    logic signed [DeltaW-1:0] delta_x;
    logic [1:0]               touch_status;
    logic [CoordW-1:0]        pos_y;
    logic [CoordW-1:0]        pos_x;
  } result_t;

  typedef struct packed {
    logic [CoordW-1:0] last_x;
    logic [CoordW-1:0] last_y;
    trk_state_e        state;
  } track_t;

endpackage

// File: hw/rtl/tet_report_eval.sv
// Combinational evaluation of one report: mirroring, status update and deltas.
module tet_report_eval import tet_pkg::*; (
  input  item_t             item_i,
  input  logic [CoordW-1:0] x_extent_i,
  input  logic [CoordW-1:0] y_extent_i,
  input  track_t            track_i,
  output result_t           result_o,
  output track_t            track_o
);

  function automatic logic [CoordW-1:0] mirror(logic [CoordW-1:0] raw,
                                               logic [CoordW-1:0] extent);
    logic [CoordW-1:0] res;
    res = '0;
    if (raw < extent) begin
      res = extent - raw - {{(CoordW-1){1'b0}}, 1'b1};
    end
    return res;
  endfunction

  function automatic logic [1:0] dir_of(logic signed [DeltaW-1:0] d);
    logic [1:0] res;
    res = DirNone;
    if (d[DeltaW-1]) begin
      res = DirNeg;
    end else if (d != '0) begin
      res = DirPos;
    end
    return res;
  endfunction

  logic                     touch;
  logic [CoordW-1:0]        raw_x, raw_y;
  logic [CoordW-1:0]        pos_x, pos_y;
  trk_state_e               next_state;
  logic [1:0]               status;
  logic signed [DeltaW-1:0] dx, dy;

  assign touch = (item_i.status_byte[3:0] == OneTouchNib);
  assign raw_x = {item_i.x_high_byte[3:0], item_i.x_low_byte};
  assign raw_y = {item_i.y_high_byte[3:0], item_i.y_low_byte};
  assign pos_x = touch ? mirror(raw_x, x_extent_i) : NoTouchCoord;
  assign pos_y = touch ? mirror(raw_y, y_extent_i) : NoTouchCoord;

  always_comb begin
    case (track_i.state)
      TrkJustTouch, TrkTouched: begin
        next_state = touch ? TrkTouched : TrkJustPop;
      end
      TrkNone, TrkJustPop: begin
        next_state = touch ? TrkJustTouch : TrkNone;
      end
      default: begin
        next_state = touch ? TrkJustTouch : TrkNone;
      end
    endcase
  end

  always_comb begin
    case (next_state)
      TrkNone:      status = StNone;
      TrkJustTouch: status = StJustTouch;
      TrkTouched:   status = StTouched;
      TrkJustPop:   status = StJustPop;
      default:      status = StNone;
    endcase
  end

  assign dx = $signed({1'b0, pos_x}) - $signed({1'b0, track_i.last_x});
  assign dy = $signed({1'b0, pos_y}) - $signed({1'b0, track_i.last_y});

  always_comb begin
    result_o.pos_x        = pos_x;
    result_o.pos_y        = pos_y;
    result_o.touch_status = status;
    result_o.delta_x      = '0;
    result_o.delta_y      = '0;
    result_o.dir_x        = DirNone;
    result_o.dir_y        = DirNone;
    if (next_state == TrkTouched) begin
      result_o.delta_x = dx;
      result_o.delta_y = dy;
      result_o.dir_x   = dir_of(dx);
      result_o.dir_y   = dir_of(dy);
    end
  end

  assign track_o.last_x = pos_x;
  assign track_o.last_y = pos_y;
  assign track_o.state  = next_state;

endmodule

// File: hw/rtl/touch_event_tracker_core.sv
// Top level of the touch event tracker: item registers, tracking state and config.
//
// Each input item on the s_axis channel is one touch-controller report. Each
// accepted item yields exactly one result item on the m_axis channel, in order.
// The cfg channel writes the panel extents used to mirror X and Y; index 0 is
// the X extent and index 1 the Y extent, and other indexes are ignored. It is
// always ready, and it should be written only while no item is in flight.
// An accepted item sits in the input register, then the evaluation logic fills
// the result register, from which m_axis shows it. One item can be accepted
// every cycle while the receiver does not stall; the tracking state updates as
// each item enters the result register.
// If the receiver stalls, the result register holds its item and the input
// register still takes one more item; s_axis_tready falls only when both
// are full. Reset empties both registers, returns the tracking state to no
// touch with zero previous coordinates, and loads extents of 480 and 800.
module touch_event_tracker_core import tet_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // status_byte, x_high_byte, x_low_byte, y_high_byte, y_low_byte
  input  logic [39:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pos_x, pos_y, touch_status, delta_x, delta_y, dir_x, dir_y
  output logic [55:0]         m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CoordW-1:0]   cfg_data_i
);

  item_t             in_item_q;
  logic              in_valid_q;
  result_t           res_q, res_d;
  logic              out_valid_q;
  track_t            track_q, track_d;
  logic [CoordW-1:0] x_ext_q, y_ext_q;
  logic              out_free, advance, in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  tet_report_eval u_eval (
    .item_i     (in_item_q),
    .x_extent_i (x_ext_q),
    .y_extent_i (y_ext_q),
    .track_i    (track_q),
    .result_o   (res_d),
    .track_o    (track_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      track_q.last_x <= '0;
      track_q.last_y <= '0;
      track_q.state  <= TrkNone;
      x_ext_q        <= XExtentReset;
      y_ext_q        <= YExtentReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        track_q     <= track_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == RegXExtent) begin
          x_ext_q <= cfg_data_i;
        end else if (cfg_addr_i == RegYExtent) begin
          y_ext_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= item_t'(s_axis_tdata);
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  a_untouched_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.touch_status == StNone || res_q.touch_status == StJustPop)
    |-> res_q.pos_x == NoTouchCoord && res_q.pos_y == NoTouchCoord)
    else $error("untouched result carries a coordinate");

  a_zero_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.touch_status != StTouched
    |-> res_q.delta_x == '0 && res_q.delta_y == '0 &&
        res_q.dir_x == DirNone && res_q.dir_y == DirNone)
    else $error("delta outside the touched status");

  a_dir_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.touch_status == StTouched
    |-> (res_q.delta_x == '0) == (res_q.dir_x == DirNone) &&
        (res_q.delta_y == '0) == (res_q.dir_y == DirNone))
    else $error("direction disagrees with delta");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_item_q))
    else $error("stalled input item lost");

  a_state_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(track_q))
    else $error("tracking state moved without an item");

endmodule

// File: verif/touch_event_checker.sv
// Checker that predicts and compares the results of the touch event tracker.
`timescale 1ns / 100ps

module touch_event_checker import tet_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [39:0]         in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [55:0]         out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CoordW-1:0]   cfg_data_i,
  input  logic                drain_done_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  logic [CoordW-1:0] x_span;
  logic [CoordW-1:0] y_span;
  logic [CoordW-1:0] prev_x;
  logic [CoordW-1:0] prev_y;
  logic [1:0]        prev_phase;
  result_t           expected_reports[$];
  result_t           got;
  result_t           want;
  int                fails;
  int                checked;
  bit                leftovers_done;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  task automatic note_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fails++;
  endtask

  task automatic check_field(input string name, input int seen, input int wanted);
    if (seen != wanted) note_mismatch($sformatf("%s is %0d, expected %0d", name, seen, wanted));
  endtask

  function automatic logic [CoordW-1:0] mirror(logic [CoordW-1:0] raw,
                                               logic [CoordW-1:0] span);
    if (raw < span) return span - raw - 1'b1;
    return '0;
  endfunction

  function automatic logic [1:0] direction(int d);
    if (d > 0) return DirPos;
    if (d < 0) return DirNeg;
    return DirNone;
  endfunction

  // Works out the result of one report from the tracking state held here.
  function automatic result_t track_report(item_t rep);
    result_t r;
    logic    touch;
    int      dx;
    int      dy;
    r = '0;
    touch = rep.status_byte[3:0] == OneTouchNib;
    r.pos_x = NoTouchCoord;
    r.pos_y = NoTouchCoord;
    if (touch) begin
      r.pos_x = mirror({rep.x_high_byte[3:0], rep.x_low_byte}, x_span);
      r.pos_y = mirror({rep.y_high_byte[3:0], rep.y_low_byte}, y_span);
    end
    if (prev_phase == StJustTouch || prev_phase == StTouched) begin
      r.touch_status = touch ? StTouched : StJustPop;
    end else begin
      r.touch_status = touch ? StJustTouch : StNone;
    end
    if (r.touch_status == StTouched) begin
      dx = int'(r.pos_x) - int'(prev_x);
      dy = int'(r.pos_y) - int'(prev_y);
      r.delta_x = dx[DeltaW-1:0];
      r.delta_y = dy[DeltaW-1:0];
      r.dir_x = direction(dx);
      r.dir_y = direction(dy);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_span = XExtentReset;
      y_span = YExtentReset;
      prev_x = '0;
      prev_y = '0;
      prev_phase = StNone;
      expected_reports.delete();
      fails = 0;
      checked = 0;
      leftovers_done = 1'b0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = result_t'(out_data_i);
        if (expected_reports.size() == 0) begin
          note_mismatch("result item arrived with no report pending");
        end else begin
          want = expected_reports.pop_front();
          check_field("pos_x", int'(got.pos_x), int'(want.pos_x));
          check_field("pos_y", int'(got.pos_y), int'(want.pos_y));
          check_field("touch_status", int'(got.touch_status), int'(want.touch_status));
          check_field("delta_x", int'(got.delta_x), int'(want.delta_x));
          check_field("delta_y", int'(got.delta_y), int'(want.delta_y));
          check_field("dir_x", int'(got.dir_x), int'(want.dir_x));
          check_field("dir_y", int'(got.dir_y), int'(want.dir_y));
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = track_report(item_t'(in_data_i));
        expected_reports.push_back(want);
        prev_x = want.pos_x;
        prev_y = want.pos_y;
        prev_phase = want.touch_status;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_addr_i == RegXExtent) x_span = cfg_data_i;
        else if (cfg_addr_i == RegYExtent) y_span = cfg_data_i;
      end
      if (drain_done_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        foreach (expected_reports[i]) note_mismatch("expected result item never arrived");
      end
      pending_o <= expected_reports.size();
    end
  end

endmodule

// File: verif/tb.sv
// Top of the touch event tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb import tet_pkg::*; ();

  localparam int CycleLimit = 400000;

  logic                clk;
  logic                rst_n;
  logic                s_tvalid;
  logic                s_tready;
  item_t               s_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [55:0]         m_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CoordW-1:0]   cfg_data;
  logic                drain_done;
  logic                calm;
  logic [CoordW-1:0]   x_span_now;
  logic [CoordW-1:0]   y_span_now;
  int                  reports_sent;
  int                  settings_used;
  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  touch_event_tracker_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  touch_event_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .drain_done_i (drain_done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("touch_event_tracker_core regression: fail");
    $finish;
  end

  function automatic item_t report_of(logic [7:0] status, logic [11:0] rx, logic [11:0] ry);
    item_t      rep;
    logic [3:0] upper_x;
    logic [3:0] upper_y;
    upper_x = 4'($urandom_range(15));
    upper_y = 4'($urandom_range(15));
    rep.status_byte = status;
    rep.x_high_byte = {upper_x, rx[11:8]};
    rep.x_low_byte  = rx[7:0];
    rep.y_high_byte = {upper_y, ry[11:8]};
    rep.y_low_byte  = ry[7:0];
    return rep;
  endfunction

  function automatic logic [7:0] touch_status_byte();
    logic [3:0] upper;
    upper = 4'($urandom_range(15));
    return {upper, OneTouchNib};
  endfunction

  // Any low nibble but one: zero or several touch points.
  function automatic logic [7:0] lift_status_byte();
    logic [3:0] upper;
    logic [3:0] nib;
    upper = 4'($urandom_range(15));
    nib = 4'($urandom_range(14));
    if (nib != 0) nib = nib + 1'b1;
    return {upper, nib};
  endfunction

  function automatic logic [11:0] pick_raw(logic [11:0] span);
    if (span != 0 && $urandom_range(99) < 85) return 12'($urandom_range(span - 1));
    return 12'($urandom_range(4095));
  endfunction

  function automatic item_t random_report();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return item_t'(w[39:0]);
  endfunction

  task automatic send_report(input item_t rep);
    while (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rep;
    do @(posedge clk); while (!s_tready);
    reports_sent++;
  endtask

  task automatic wait_drained(input int spare);
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 5000);
    repeat (spare) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CoordW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_extents(input logic [CoordW-1:0] xs, input logic [CoordW-1:0] ys);
    logic [CfgAddrW-1:0] stray_idx;
    stray_idx = CfgAddrW'($urandom_range(RegYExtent + 1, 2 ** CfgAddrW - 1));
    wait_drained(4);
    write_reg(RegXExtent, xs);
    write_reg(RegYExtent, ys);
    write_reg(stray_idx, 12'($urandom_range(4095)));
    cfg_valid <= 1'b0;
    x_span_now = xs;
    y_span_now = ys;
    settings_used++;
  endtask

  // One finger down for a while, drifting or jumping, then lifted.
  task automatic send_gesture();
    int          len;
    logic [11:0] rx;
    logic [11:0] ry;
    len = $urandom_range(1, 24);
    rx = pick_raw(x_span_now);
    ry = pick_raw(y_span_now);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(9) < 7) begin
        rx = rx + 12'($urandom_range(32)) - 12'd16;
        ry = ry + 12'($urandom_range(32)) - 12'd16;
      end else if (i > 0) begin
        rx = pick_raw(x_span_now);
        ry = pick_raw(y_span_now);
      end
      send_report(report_of(touch_status_byte(), rx, ry));
    end
    repeat ($urandom_range(1, 3)) begin
      send_report(report_of(lift_status_byte(), 12'($urandom_range(4095)),
                            12'($urandom_range(4095))));
    end
  endtask

  initial begin
    int target;
    rst_n      <= 1'b0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    cfg_valid  <= 1'b0;
    cfg_addr   <= '0;
    cfg_data   <= '0;
    drain_done <= 1'b0;
    calm       <= 1'b0;
    reports_sent = 0;
    settings_used = 1;
    x_span_now = XExtentReset;
    y_span_now = YExtentReset;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_report(report_of(8'h00, 12'd0, 12'd0));
    send_report(report_of(8'h01, 12'd0, 12'd0));
    send_report(report_of(8'h01, 12'd479, 12'd799));
    send_report(report_of(8'h01, 12'd480, 12'd800));
    send_report(report_of(8'hF1, 12'hFFF, 12'hFFF));
    send_report(report_of(8'h31, 12'd100, 12'd200));
    send_report(report_of(8'h01, 12'd100, 12'd200));
    send_report(report_of(8'h02, 12'd100, 12'd200));
    send_report(report_of(8'h0F, 12'd7, 12'd9));
    send_report(report_of(8'h21, 12'd5, 12'd5));
    send_report(report_of(8'h10, 12'd5, 12'd5));
    send_report(report_of(8'hFF, 12'hFFF, 12'hFFF));

    set_extents(12'd0, 12'hFFF);
    send_report(report_of(8'h01, 12'd0, 12'd0));
    send_report(report_of(8'h01, 12'hFFF, 12'd4094));
    send_report(report_of(8'h01, 12'd1234, 12'd0));
    send_report(report_of(8'h00, 12'd0, 12'd0));

    set_extents(12'hFFF, 12'd1);
    send_report(report_of(8'h01, 12'd0, 12'd0));
    send_report(report_of(8'h01, 12'd4094, 12'd1));
    send_report(report_of(8'h01, 12'd0, 12'd0));
    send_report(report_of(8'hE0, 12'd0, 12'd0));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_extents(XExtentReset, YExtentReset);
        1: set_extents(12'd1, 12'd1);
        3: set_extents(12'hFFF, 12'hFFF);
        default: set_extents(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
      endcase
      calm <= (ph == 2);
      target = reports_sent + 250;
      while (reports_sent < target) begin
        if ($urandom_range(99) < 80) send_gesture();
        else send_report(random_report());
      end
    end

    calm <= 1'b0;
    wait_drained(10);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d reports and %0d checked results over %0d extent settings,",
             reports_sent, checked, settings_used);
    $display("with zero and full-scale extents, multi-touch bytes and ignored registers.");
    if (fail_count == 0) begin
      $display("touch_event_tracker_core regression: pass");
    end else begin
      $display("touch_event_tracker_core regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tet_pkg.sv
hw/rtl/tet_report_eval.sv
hw/rtl/touch_event_tracker_core.sv
verif/touch_event_checker.sv
verif/tb.sv
